// File: sv/kmnca_pkg.sv
// Shared constants and types for the k-means nearest centroid assignment core.
// Used by the cell, the RAM users and the top level; depends on nothing else.
`default_nettype none

package kmnca_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_FEATURES = 64;
  localparam int VALUE_BITS   = 16;

  localparam int CLW        = $clog2(MAX_CLUSTERS);
  localparam int FTW        = $clog2(MAX_FEATURES);
  localparam int CNW        = $clog2(MAX_CLUSTERS + 1);
  localparam int FNW        = $clog2(MAX_FEATURES + 1);
  localparam int SQ_BITS    = 2 * VALUE_BITS;
  localparam int DIST_BITS  = 38;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'd1;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_WAIT,
    ST_SCAN
  } state_e;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic                  we;
    logic [CLW-1:0]        wcl;
    logic [FTW-1:0]        waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [FTW-1:0]        raddr;
    logic [VALUE_BITS-1:0] x;
    logic                  mul_en;
    logic                  acc_en;
    logic                  clr;
    logic [CNW-1:0]        nclus;
  } ctrl_t;

  // Running minimum handed from one cell to the next
  typedef struct packed {
    logic                 vld;
    logic [DIST_BITS-1:0] best;
    logic [CLW-1:0]       lbl;
  } link_t;

endpackage

`default_nettype wire

// File: sv/kmnca_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module kmnca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/kmnca_cell.sv
// One cluster cell: centroid RAM, squared-difference stage, saturating
// accumulator and one stage of the minimum-search chain. Uses kmnca_pkg, kmnca_ram.
`default_nettype none

module kmnca_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [kmnca_pkg::CLW-1:0]     idx_i,
  input  wire kmnca_pkg::ctrl_t              ctrl_i,
  input  wire kmnca_pkg::link_t              link_i,
  output kmnca_pkg::link_t                   link_o
);
  import kmnca_pkg::*;

  logic [VALUE_BITS-1:0] cent;
  logic signed [VALUE_BITS:0] diff;
  logic [VALUE_BITS:0]   neg;
  logic [VALUE_BITS-1:0] absd;
  logic [SQ_BITS-1:0]    sq_q;
  logic [DIST_BITS-1:0]  acc_q, acc_d;
  logic [DIST_BITS:0]    sum;
  logic                  take;
  logic                  vld_q;
  logic [DIST_BITS-1:0]  best_q;
  logic [CLW-1:0]        lbl_q;

  kmnca_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_FEATURES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.we && (ctrl_i.wcl == idx_i)),
    .waddr_i(ctrl_i.waddr),
    .wdata_i(ctrl_i.wdata),
    .raddr_i(ctrl_i.raddr),
    .rdata_o(cent)
  );

  always_comb begin
    diff = $signed({ctrl_i.x[VALUE_BITS-1], ctrl_i.x}) - $signed({cent[VALUE_BITS-1], cent});
    neg  = ~diff + 1'b1;
    absd = diff[VALUE_BITS] ? neg[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
    sum  = {1'b0, acc_q} + (DIST_BITS + 1)'(sq_q);
    // saturate at the largest representable distance
    acc_d = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
    take  = ({1'b0, idx_i} < ctrl_i.nclus) && (acc_q < link_i.best);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      sq_q <= absd * absd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= link_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_i.vld) begin
      best_q <= take ? acc_q : link_i.best;
      lbl_q  <= take ? idx_i : link_i.lbl;
    end
  end

  assign link_o = '{vld: vld_q, best: best_q, lbl: lbl_q};

endmodule

`default_nettype wire

// File: sv/kmeans_nearest_centroid_assign_core.sv
// Nearest centroid assignment: a row of MAX_CLUSTERS cells, each with its own
// centroid RAM and accumulator; a search token walks the row to find the minimum.
// Load: writes one cell's RAM. Sample coordinate: RAM read, square, add, with
// the input stalled. Last coordinate: then a chain walk of MAX_CLUSTERS cells.
// Reset clears accumulators, position and handshake state; counts reset to 1.
// Centroid RAM contents are undefined until loaded. Depends on kmnca_pkg.
`default_nettype none

module kmeans_nearest_centroid_assign_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                req_type_i,
  input  wire logic [3:0]                          cluster_index_i,
  input  wire logic [5:0]                          feature_index_i,
  input  wire logic signed [15:0]                  coord_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [3:0]                               label_o,
  output logic [37:0]                              min_distance_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [kmnca_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [kmnca_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import kmnca_pkg::*;

  state_e                state_q, state_d;
  logic [CNW-1:0]        ccount_q;
  logic [FNW-1:0]        fcount_q;
  logic [CNW-1:0]        nclus;
  logic [FNW-1:0]        nfeat;
  logic [FTW-1:0]        pos_q;
  logic [VALUE_BITS-1:0] x_q;
  logic                  out_valid_q;
  logic [CLW-1:0]        label_q;
  logic [DIST_BITS-1:0]  dist_q;
  logic                  accept, sample_acc, last, start, finish;
  ctrl_t                 ctrl;
  link_t                 link [MAX_CLUSTERS+1];

  assign accept     = in_valid_i && !in_stall_o;
  assign sample_acc = accept && (req_type_i == REQ_SAMPLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    nclus = ccount_q;
    if (ccount_q == '0) nclus = CNW'(1);
    else if (ccount_q > CNW'(MAX_CLUSTERS)) nclus = CNW'(MAX_CLUSTERS);
    nfeat = fcount_q;
    if (fcount_q == '0) nfeat = FNW'(1);
    else if (fcount_q > FNW'(MAX_FEATURES)) nfeat = FNW'(MAX_FEATURES);
  end

  assign last   = (FNW'(pos_q) + FNW'(1)) >= nfeat;
  assign finish = link[MAX_CLUSTERS].vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccount_q <= CNW'(1);
      fcount_q <= FNW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_CLUSTER_COUNT: ccount_q <= cfg_data_i[CNW-1:0];
        REG_FEATURE_COUNT: fcount_q <= cfg_data_i[FNW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    start      = 1'b0;
    ctrl       = '0;
    ctrl.wcl   = cluster_index_i;
    ctrl.waddr = feature_index_i;
    ctrl.wdata = coord_value_i;
    ctrl.raddr = pos_q;
    ctrl.x     = x_q;
    ctrl.nclus = nclus;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ctrl.we = in_valid_i && (req_type_i == REQ_LOAD);
        if (in_valid_i && (req_type_i == REQ_SAMPLE)) state_d = ST_MUL;
      end
      ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        ctrl.acc_en = 1'b1;
        state_d = last ? ST_WAIT : ST_IDLE;
      end
      ST_WAIT: begin
        // hold the search until the output register is free
        if (!out_valid_q) begin
          start   = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          ctrl.clr = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (state_q == ST_SCAN && finish) begin
      pos_q <= '0;
    end else if (state_q == ST_ACC && !last) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      x_q <= coord_value_i;
    end
  end

  assign link[0].vld  = start;
  assign link[0].best = DIST_MAX;
  assign link[0].lbl  = '0;

  for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
    kmnca_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .idx_i (CLW'(k)),
      .ctrl_i(ctrl),
      .link_i(link[k]),
      .link_o(link[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_SCAN && finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && finish) begin
      label_q <= link[MAX_CLUSTERS].lbl;
      dist_q  <= link[MAX_CLUSTERS].best;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign label_o        = label_q;
  assign min_distance_o = dist_q;

endmodule

`default_nettype wire
